### rtl/core/assert_macros.svh
// assertion macros shared by the stack alu rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every edge out of reset
`define CHK_HOLD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that forces a consequence in the next cycle
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/stk_alu_pkg.sv
// shared types and constants for the stack alu
// no dependencies
`default_nettype none

package stk_alu_pkg;

  localparam int DATA_W = 32;
  localparam int STACK_DEPTH_DEF = 16;

  // operation carried by an input beat
  typedef enum logic [2:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_MUL  = 3'd2,
    MODE_SUB  = 3'd3,
    MODE_MOD  = 3'd4,
    MODE_DROP = 3'd5,
    MODE_DUP  = 3'd6,
    MODE_NONE = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FEW  = 2'd1,
    ST_OVER = 2'd2,
    ST_DIVZ = 2'd3
  } status_t;

  // what a stack cell does on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_UP   = 2'd2,
    CELL_FROM_DOWN = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

### rtl/core/stk_alu_cell.sv
// one stack entry of the shift-register stack
// depends on stk_alu_pkg
`default_nettype none

module stk_alu_cell
  import stk_alu_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_op_t          op,
  input  wire logic [DATA_W-1:0] load_data,
  input  wire logic [DATA_W-1:0] up_data,
  input  wire logic [DATA_W-1:0] down_data,
  output logic      [DATA_W-1:0] data_q
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    case (op)
      CELL_HOLD:      data_nxt = data_r;
      CELL_LOAD:      data_nxt = load_data;
      CELL_FROM_UP:   data_nxt = up_data;
      CELL_FROM_DOWN: data_nxt = down_data;
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

`default_nettype wire

### rtl/core/stk_alu_div.sv
// bit-serial signed remainder unit, one dividend bit per cycle
// depends on stk_alu_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module stk_alu_div
  import stk_alu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output div_res_t               res
);

  localparam int STEP_W = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      // work on magnitudes, remainder takes the dividend's sign
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
      dvs_nxt  = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
      rem_nxt  = '0;
      neg_nxt  = dividend[DATA_W-1];
    end else if (busy_r) begin
      rem_nxt  = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
      quo_nxt  = {quo_r[DATA_W-2:0], 1'b0};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
  end

  assign res.done = done_r;
  assign res.rem  = neg_r ? (~rem_r + DATA_W'(1)) : rem_r;

  `CHK_HOLD(a_start_when_idle, (!start || !busy_r), "divider started while busy")
  `CHK_NEXT(a_done_single, done_r, (!done_r && !busy_r), "divider done held or busy after done")

endmodule

`default_nettype wire

### rtl/core/stack_alu.sv
// Bounded operand stack with a small ALU. The stack is a row of STACK_DEPTH
// cells, cell 0 holding the top; push and dup shift the row down, binary
// operations, drop and pops shift it up. One beat in gives one beat out with
// the new top, the depth and a status. Push, add, subtract, multiply, drop,
// dup and beats that leave the stack unchanged (too few entries, overflow,
// modulo by zero, unused mode) go through an update, then result staging,
// which waits out a stalled output; a modulo that runs first waits on the
// bit-serial divider, one dividend bit per cycle. A new beat is taken
// while the previous result still waits at the output register.
// depends on stk_alu_pkg, stk_alu_cell, stk_alu_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module stack_alu
  import stk_alu_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [2:0]  in_mode,
  input  wire logic signed [31:0] in_operand_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [31:0] out_top_value,
  output logic             [4:0]  out_stack_depth,
  output logic             [1:0]  out_status
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] MIN_OPS = CNT_W'(2);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_PEND = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  status_t           status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_top_r;
  logic [4:0]        out_depth_r;
  status_t           out_status_r;

  logic [DATA_W-1:0] cell_q [STACK_DEPTH];
  cell_op_t          op_top, op_rest;
  logic [DATA_W-1:0] load_data;
  logic [DATA_W-1:0] top_a, top_b;
  logic              accept, full, few, out_load, div_start;
  div_res_t          div_res;

  assign top_a  = cell_q[0];
  assign top_b  = cell_q[1];
  assign accept = in_valid && !in_stall;
  assign full   = (cnt_r >= DEPTH_C);
  assign few    = (cnt_r < MIN_OPS);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    op_top     = CELL_HOLD;
    op_rest    = CELL_HOLD;
    load_data  = in_operand_value;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_PEND;
          status_nxt = ST_DONE;
          case (in_mode)
            MODE_PUSH: begin
              if (full) begin
                status_nxt = ST_OVER;
              end else begin
                op_top  = CELL_LOAD;
                op_rest = CELL_FROM_UP;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            MODE_ADD, MODE_MUL, MODE_SUB: begin
              if (few) begin
                status_nxt = ST_FEW;
              end else begin
                if (in_mode == MODE_ADD) begin
                  load_data = top_a + top_b;
                end else if (in_mode == MODE_MUL) begin
                  load_data = top_a * top_b;
                end else begin
                  load_data = top_a - top_b;
                end
                op_top  = CELL_LOAD;
                op_rest = CELL_FROM_DOWN;
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            MODE_MOD: begin
              if (few) begin
                status_nxt = ST_FEW;
              end else if (top_b == '0) begin
                status_nxt = ST_DIVZ;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            MODE_DROP: begin
              if (few) begin
                status_nxt = ST_FEW;
              end else begin
                op_top  = CELL_FROM_DOWN;
                op_rest = CELL_FROM_DOWN;
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            MODE_DUP: begin
              if (few) begin
                status_nxt = ST_FEW;
              end else if (full) begin
                status_nxt = ST_OVER;
              end else begin
                op_rest = CELL_FROM_UP;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            default: begin
              // unused mode: stack untouched, reported as done
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          load_data = div_res.rem;
          op_top    = CELL_LOAD;
          op_rest   = CELL_FROM_DOWN;
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_PEND;
        end
      end
      S_PEND: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      status_r    <= ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_top_r    <= (cnt_r == '0) ? '0 : top_a;
      out_depth_r  <= 5'(cnt_r);
      out_status_r <= status_r;
    end
  end

  // cell 0 is the top; each cell sees the one above and the one below
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up_data;
    logic [DATA_W-1:0] down_data;
    if (i == 0) begin : g_first
      assign up_data = '0;
    end else begin : g_mid_up
      assign up_data = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_data = '0;
    end else begin : g_mid_down
      assign down_data = cell_q[i+1];
    end
    stk_alu_cell u_cell (
      .clk       (clk),
      .op        ((i == 0) ? op_top : op_rest),
      .load_data (load_data),
      .up_data   (up_data),
      .down_data (down_data),
      .data_q    (cell_q[i])
    );
  end

  stk_alu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (top_a),
    .divisor  (top_b),
    .res      (div_res)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_stack_depth = out_depth_r;
  assign out_status      = out_status_r;

  `CHK_HOLD(a_cnt_bound, (cnt_r <= DEPTH_C), "entry count above stack depth")
  `CHK_NEXT(a_accept_busy, accept, (state_r != S_IDLE), "accepted beat left no work")
  `CHK_HOLD(a_div_in_div, (!div_res.done || state_r == S_DIV), "divider result outside modulo")
  `CHK_NEXT(a_pend_out, (state_r == S_PEND && state_nxt == S_IDLE), out_valid_r,
    "pending result not staged")

endmodule

`default_nettype wire
